@@ rtl/uvs_pkg.sv @@
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and codes for the stack of distinct values.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int VAL_W = 32;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic push_shift;
    logic pop_shift;
    logic load_flag;
    logic or_step;
  } cell_ctl_t;

endpackage

@@ rtl/uvs_if.sv @@
// ----------------------------------------------------------------------------
// uvs_if
// Valid/ready channels for operations in and results out.
// ----------------------------------------------------------------------------
interface uvs_in_if
  import uvs_pkg::*;
;
  logic valid;
  logic ready;
  logic action;
  val_t push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink (input valid, input action, input push_value, output ready);
endinterface

interface uvs_out_if
  import uvs_pkg::*;
;
  logic       valid;
  logic       ready;
  val_t       popped_value;
  logic [1:0] status;

  modport source (output valid, output popped_value, output status, input ready);
  modport sink (input valid, input popped_value, input status, output ready);
endinterface

@@ rtl/uvs_cell.sv @@
// ----------------------------------------------------------------------------
// uvs_cell
// One stack slot: entry, live bit and a match flag that merges towards the top.
// ----------------------------------------------------------------------------
module uvs_cell
  import uvs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  val_t      key,
  input  val_t      up_entry,
  input  logic      up_live,
  input  val_t      dn_entry,
  input  logic      dn_live,
  input  logic      dn_flag,
  output val_t      entry,
  output logic      live,
  output logic      flag
);

  val_t entry_r, entry_nxt;
  logic live_r, live_nxt;
  logic flag_r, flag_nxt;

  always_comb begin
    entry_nxt = entry_r;
    live_nxt  = live_r;
    flag_nxt  = flag_r;
    if (ctl.push_shift) begin
      entry_nxt = up_entry;
      live_nxt  = up_live;
    end else if (ctl.pop_shift) begin
      entry_nxt = dn_entry;
      live_nxt  = dn_live;
    end
    if (ctl.load_flag) begin
      flag_nxt = live_r && (entry_r == key);
    end else if (ctl.or_step) begin
      flag_nxt = flag_r | dn_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    flag_r  <= flag_nxt;
  end

  assign entry = entry_r;
  assign live  = live_r;
  assign flag  = flag_r;

endmodule

@@ rtl/unique_value_stack.sv @@
// ----------------------------------------------------------------------------
// unique_value_stack
// Fixed-depth stack of distinct signed values built as a row of cells.
// ----------------------------------------------------------------------------
// The stack lives in a row of DEPTH cells with the top entry in the first
// cell; a push shifts every entry one cell down, a pop one cell up. Each
// transaction gives exactly one result. A pop writes its result straight
// to the output register. A push first compares its value in every live
// cell at once, then merges the match flags one cell per cycle towards the
// top while the input is not ready, and then resolves. A finished result
// waits in the output register, and the next transaction is taken only once
// that register is empty or is read in the same cycle.
module unique_value_stack
  import uvs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic      clk,
  input logic      rst_n,
  uvs_in_if.sink   in_chan,
  uvs_out_if.source out_chan
);

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  val_t          key_r, key_nxt;
  logic          out_valid_r, out_valid_nxt;
  val_t          out_value_r, out_value_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  val_t      entry_w [DEPTH];
  logic      live_w  [DEPTH];
  logic      flag_w  [DEPTH];
  cell_ctl_t ctl;

  logic accept, resolve, is_full, is_empty;

  assign in_chan.ready = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign resolve       = (state_r == S_SCAN) && (rem_r == '0);
  assign is_full       = (count_r == CW'(DEPTH));
  assign is_empty      = (count_r == '0);

  assign ctl.load_flag  = accept && (in_chan.action == ACT_PUSH);
  assign ctl.or_step    = (state_r == S_SCAN) && (rem_r != '0);
  assign ctl.push_shift = resolve && !flag_w[0] && !is_full;
  assign ctl.pop_shift  = accept && (in_chan.action == ACT_POP) && !is_empty;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      val_t up_entry, dn_entry;
      logic up_live, dn_live, dn_flag;
      if (gi == 0) begin : g_top
        assign up_entry = key_r;
        assign up_live  = 1'b1;
      end else begin : g_mid
        assign up_entry = entry_w[gi-1];
        assign up_live  = live_w[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_bot
        assign dn_entry = '0;
        assign dn_live  = 1'b0;
        assign dn_flag  = 1'b0;
      end else begin : g_inner
        assign dn_entry = entry_w[gi+1];
        assign dn_live  = live_w[gi+1];
        assign dn_flag  = flag_w[gi+1];
      end
      uvs_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .key      (in_chan.push_value),
        .up_entry (up_entry),
        .up_live  (up_live),
        .dn_entry (dn_entry),
        .dn_live  (dn_live),
        .dn_flag  (dn_flag),
        .entry    (entry_w[gi]),
        .live     (live_w[gi]),
        .flag     (flag_w[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (accept) begin
      if (in_chan.action == ACT_PUSH) begin
        key_nxt   = in_chan.push_value;
        rem_nxt   = is_empty ? '0 : count_r - CW'(1);
        state_nxt = S_SCAN;
      end else begin
        out_valid_nxt = 1'b1;
        if (is_empty) begin
          out_value_nxt  = '0;
          out_status_nxt = ST_EMPTY;
        end else begin
          out_value_nxt  = entry_w[0];
          out_status_nxt = ST_DONE;
          count_nxt      = count_r - CW'(1);
        end
      end
    end else if (resolve) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      out_value_nxt = '0;
      if (flag_w[0]) begin
        out_status_nxt = ST_DUP;
      end else if (is_full) begin
        out_status_nxt = ST_FULL;
      end else begin
        out_status_nxt = ST_DONE;
        count_nxt      = count_r + CW'(1);
      end
    end else if (state_r == S_SCAN) begin
      rem_nxt = rem_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    key_r        <= key_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.popped_value = out_value_r;
  assign out_chan.status       = out_status_r;

endmodule
